// ===== src/morse_hex_digit_decoder_defines.svh =====
// Assertion macros for the morse hex digit decoder checker.
`ifndef MORSE_HEX_DIGIT_DECODER_DEFINES_SVH
`define MORSE_HEX_DIGIT_DECODER_DEFINES_SVH

// Check a property outside of reset.
`define MHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mhd_pkg.sv =====
`timescale 1ns / 1ps
package mhd_pkg;

  localparam int MAX_SYMBOLS = 5;
  localparam int LEN_W       = 20;
  localparam int CAP_W       = 16;
  localparam int GAP_W       = 4;
  localparam int DIGIT_W     = 5;
  localparam int CFG_W       = 20;
  localparam int CNT_W       = 3;

  localparam logic [LEN_W-1:0]   LEN_MAX          = '1;
  localparam logic [LEN_W-1:0]   DOT_MIN_RESET    = 20'd30000;
  localparam logic [LEN_W-1:0]   DASH_SPLIT_RESET = 20'd200000;
  localparam logic [LEN_W-1:0]   DASH_MAX_RESET   = 20'd400000;
  localparam logic [GAP_W-1:0]   GAP_TICKS_RESET  = 4'd8;
  localparam logic [GAP_W-1:0]   GAP_COUNT_MAX    = '1;
  localparam logic [DIGIT_W-1:0] DIGIT_ERR        = 5'd16;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DOT_MIN    = 2'd0,
    REG_DASH_SPLIT = 2'd1,
    REG_DASH_MAX   = 2'd2,
    REG_GAP_TICKS  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SYM_EMPTY = 2'd0,
    SYM_DOT   = 2'd1,
    SYM_DASH  = 2'd2,
    SYM_ERR   = 2'd3
  } sym_t;

  // Element 0 is the first symbol keyed.
  typedef sym_t [MAX_SYMBOLS-1:0] sym_row_t;

  typedef struct packed {
    logic [LEN_W-1:0] dot_min;
    logic [LEN_W-1:0] dash_split;
    logic [LEN_W-1:0] dash_max;
  } thr_t;

  // Rows written last symbol first.
  localparam sym_row_t CODE_TABLE [16] = '{
    {SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH},
    {SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DOT },
    {SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DOT,   SYM_DOT },
    {SYM_DASH,  SYM_DASH,  SYM_DOT,   SYM_DOT,   SYM_DOT },
    {SYM_DASH,  SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT },
    {SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT },
    {SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DASH},
    {SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DASH,  SYM_DASH},
    {SYM_DOT,   SYM_DOT,   SYM_DASH,  SYM_DASH,  SYM_DASH},
    {SYM_DOT,   SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH},
    {SYM_EMPTY, SYM_EMPTY, SYM_EMPTY, SYM_DASH,  SYM_DOT },
    {SYM_EMPTY, SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DASH},
    {SYM_EMPTY, SYM_DOT,   SYM_DASH,  SYM_DOT,   SYM_DASH},
    {SYM_EMPTY, SYM_EMPTY, SYM_DOT,   SYM_DOT,   SYM_DASH},
    {SYM_EMPTY, SYM_EMPTY, SYM_EMPTY, SYM_EMPTY, SYM_DOT },
    {SYM_EMPTY, SYM_DOT,   SYM_DASH,  SYM_DOT,   SYM_DOT }
  };

endpackage

// ===== src/morse_hex_digit_decoder.sv =====
`timescale 1ns / 1ps
// Morse hex digit decoder.
// Input channel (in_valid/in_ready): one request per key press edge, key
// release edge or timer overflow tick, with the 16-bit timer capture value.
// Output channel (out_valid/out_ready): one result per request: show and
// digit when a letter ends, reload_timer on a release and on gap ticks that
// do not decode.
// Pipeline: a request accepted into the input register has its result valid once
// it moves on into the result register (input register, then result register). Throughput: one
// request per cycle while the receiver takes results; key state updates as the result loads.
// When the receiver stalls, the result holds, the input register fills and
// in_ready drops until the result is taken; nothing is lost.
// Reset (synchronous, rst high) empties both registers, clears the key and
// symbol state and loads the threshold registers with their defaults.
// Configuration: cfg_we with cfg_index and cfg_data writes one register at
// the edge; write only while no request is in flight.
module morse_hex_digit_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] capture_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        show,
  output logic [4:0]  digit,
  output logic        reload_timer
);
  import mhd_pkg::*;

  thr_t             thr;
  logic [GAP_W-1:0] gap_ticks;

  logic             s_valid;
  logic [1:0]       s_cmd;
  logic [CAP_W-1:0] s_cap;
  logic             advance;

  logic [LEN_W-1:0] press_length, press_length_next;
  logic [CAP_W-1:0] press_start, press_start_next;
  logic             in_gap, in_gap_next;
  logic [GAP_W-1:0] gap_count, gap_count_next;
  sym_row_t         symbols, symbols_next;
  logic [CNT_W-1:0] symbol_count, symbol_count_next;
  logic             symbol_overflow, symbol_overflow_next;

  logic             show_next;
  logic [4:0]       digit_next;
  logic             reload_next;

  sym_t             sym;
  logic [4:0]       match_digit;
  logic [GAP_W-1:0] gap_inc;

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;
  assign gap_inc  = gap_count + GAP_W'(1);

  mhd_symbol u_symbol (
    .press_length (press_length),
    .press_start  (press_start),
    .capture_time (s_cap),
    .thr          (thr),
    .sym          (sym)
  );

  mhd_match u_match (
    .symbols  (symbols),
    .overflow (symbol_overflow),
    .digit    (match_digit)
  );

  always_comb begin
    press_length_next    = press_length;
    press_start_next     = press_start;
    in_gap_next          = in_gap;
    gap_count_next       = gap_count;
    symbols_next         = symbols;
    symbol_count_next    = symbol_count;
    symbol_overflow_next = symbol_overflow;
    show_next            = 1'b0;
    digit_next           = '0;
    reload_next          = 1'b0;
    case (s_cmd)
      CMD_PRESS: begin
        press_start_next  = s_cap;
        press_length_next = '0;
        in_gap_next       = 1'b0;
        gap_count_next    = '0;
      end
      CMD_RELEASE: begin
        if (symbol_count < CNT_W'(MAX_SYMBOLS)) begin
          symbols_next[symbol_count] = sym;
          symbol_count_next          = symbol_count + CNT_W'(1);
        end else begin
          symbol_overflow_next = 1'b1;
        end
        press_length_next = '0;
        in_gap_next       = 1'b1;
        gap_count_next    = '0;
        reload_next       = 1'b1;
      end
      CMD_TICK: begin
        if (!in_gap) begin
          if (&press_length[LEN_W-1:CAP_W]) begin
            press_length_next = LEN_MAX;
          end else begin
            press_length_next = press_length + (LEN_W'(1) << CAP_W);
          end
        end else if (gap_count != GAP_COUNT_MAX) begin
          gap_count_next = gap_inc;
          if (gap_inc == gap_ticks) begin
            show_next            = 1'b1;
            digit_next           = match_digit;
            symbols_next         = '{default: SYM_EMPTY};
            symbol_count_next    = '0;
            symbol_overflow_next = 1'b0;
          end else begin
            reload_next = 1'b1;
          end
        end else begin
          reload_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.dot_min    <= DOT_MIN_RESET;
      thr.dash_split <= DASH_SPLIT_RESET;
      thr.dash_max   <= DASH_MAX_RESET;
      gap_ticks      <= GAP_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT_MIN:    thr.dot_min    <= cfg_data;
        REG_DASH_SPLIT: thr.dash_split <= cfg_data;
        REG_DASH_MAX:   thr.dash_max   <= cfg_data;
        REG_GAP_TICKS:  gap_ticks      <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s_cmd <= cmd;
      s_cap <= capture_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_length    <= '0;
      press_start     <= '0;
      in_gap          <= 1'b0;
      gap_count       <= '0;
      symbols         <= '{default: SYM_EMPTY};
      symbol_count    <= '0;
      symbol_overflow <= 1'b0;
    end else if (advance) begin
      press_length    <= press_length_next;
      press_start     <= press_start_next;
      in_gap          <= in_gap_next;
      gap_count       <= gap_count_next;
      symbols         <= symbols_next;
      symbol_count    <= symbol_count_next;
      symbol_overflow <= symbol_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      show         <= show_next;
      digit        <= digit_next;
      reload_timer <= reload_next;
    end
  end

endmodule

// ===== src/mhd_symbol.sv =====
`timescale 1ns / 1ps
module mhd_symbol (
  input  logic [19:0]     press_length,
  input  logic [15:0]     press_start,
  input  logic [15:0]     capture_time,
  input  mhd_pkg::thr_t   thr,
  output mhd_pkg::sym_t   sym
);
  import mhd_pkg::*;

  logic [LEN_W+1:0] diff;
  logic [LEN_W-1:0] len;

  assign diff = {2'b00, press_length} + (LEN_W+2)'(capture_time)
              - (LEN_W+2)'(press_start);

  // Clamp to zero below, to the maximum above.
  always_comb begin
    if (diff[LEN_W+1]) begin
      len = '0;
    end else if (diff[LEN_W]) begin
      len = LEN_MAX;
    end else begin
      len = diff[LEN_W-1:0];
    end
  end

  always_comb begin
    if (len > thr.dot_min && len < thr.dash_split) begin
      sym = SYM_DOT;
    end else if (len > thr.dash_split && len < thr.dash_max) begin
      sym = SYM_DASH;
    end else begin
      sym = SYM_ERR;
    end
  end

endmodule

// ===== src/mhd_match.sv =====
`timescale 1ns / 1ps
module mhd_match (
  input  mhd_pkg::sym_row_t symbols,
  input  logic              overflow,
  output logic [4:0]        digit
);
  import mhd_pkg::*;

  // Scan high to low so the lowest matching digit wins.
  always_comb begin
    digit = DIGIT_ERR;
    for (int d = 15; d >= 0; d--) begin
      if (symbols == CODE_TABLE[d]) begin
        digit = DIGIT_W'(d);
      end
    end
    if (overflow) begin
      digit = DIGIT_ERR;
    end
  end

endmodule

// ===== src/mhd_checker.sv =====
`timescale 1ns / 1ps
`include "morse_hex_digit_decoder_defines.svh"
module mhd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       show,
  input logic [4:0] digit,
  input logic       reload_timer
);
  import mhd_pkg::*;

  `MHD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")
  `MHD_ASSERT(a_digit_range, out_valid && show |-> digit <= DIGIT_ERR, "digit out of range")
  `MHD_ASSERT(a_digit_idle, out_valid && !show |-> digit == '0, "digit set without show")
  `MHD_ASSERT(a_show_reload, out_valid |-> !(show && reload_timer), "show with reload")
  `MHD_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(digit), "stall lost")

endmodule

bind morse_hex_digit_decoder mhd_checker u_mhd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .show         (show),
  .digit        (digit),
  .reload_timer (reload_timer)
);

// ===== sim/morse_digit_checker.sv =====
`timescale 1ns / 1ps
package morse_code_pkg;

  function automatic string hex_morse(input int unsigned d);
    case (d)
      0: return "-----";
      1: return ".----";
      2: return "..---";
      3: return "...--";
      4: return "....-";
      5: return ".....";
      6: return "-....";
      7: return "--...";
      8: return "---..";
      9: return "----.";
      10: return ".-";
      11: return "-...";
      12: return "-.-.";
      13: return "-..";
      14: return ".";
      default: return "..-.";
    endcase
  endfunction

endpackage

module morse_digit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mhd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [mhd_pkg::CAP_W-1:0]   capture_time,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       show,
  input  logic [mhd_pkg::DIGIT_W-1:0] digit,
  input  logic                       reload_timer,
  output int                         fail_count,
  output int                         pending,
  output int                         letters_seen
);
  import mhd_pkg::*;
  import morse_code_pkg::*;

  typedef struct packed {
    logic               show;
    logic [DIGIT_W-1:0] digit;
    logic               reload;
  } key_result_t;

  key_result_t      result_q[$];
  logic [LEN_W-1:0] dot_min, dash_split, dash_max;
  logic [GAP_W-1:0] gap_ticks;
  logic [LEN_W-1:0] held_len;
  logic [CAP_W-1:0] held_start;
  logic             in_gap;
  logic [GAP_W-1:0] gap_count;
  string            letter;
  bit               letter_overflow;
  int               mismatches = 0;
  int               shown = 0;
  int               checked = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("[%0t] result %0d: %s", $time, checked, what);
    mismatches++;
  endtask

  function automatic string symbol_of(input logic [LEN_W-1:0] len);
    if (len > dot_min && len < dash_split) return ".";
    if (len > dash_split && len < dash_max) return "-";
    return "x";
  endfunction

  function automatic logic [DIGIT_W-1:0] decode_letter();
    if (letter_overflow) return DIGIT_ERR;
    for (int d = 0; d < 16; d++) begin
      if (letter == hex_morse(d)) return DIGIT_W'(d);
    end
    return DIGIT_ERR;
  endfunction

  function automatic key_result_t predict_key(input cmd_t c, input logic [CAP_W-1:0] t);
    key_result_t      r;
    int               span;
    logic [LEN_W:0]   grown;
    r = '0;
    case (c)
      CMD_PRESS: begin
        held_start = t;
        held_len = '0;
        in_gap = 1'b0;
        gap_count = '0;
      end
      CMD_RELEASE: begin
        span = int'(held_len) + int'(t) - int'(held_start);
        if (span < 0) span = 0;
        if (span > int'(LEN_MAX)) span = int'(LEN_MAX);
        if (letter.len() < MAX_SYMBOLS) letter = {letter, symbol_of(LEN_W'(span))};
        else letter_overflow = 1'b1;
        held_len = '0;
        in_gap = 1'b1;
        gap_count = '0;
        r.reload = 1'b1;
      end
      CMD_TICK: begin
        if (!in_gap) begin
          grown = held_len + 21'h10000;
          held_len = (grown > LEN_MAX) ? LEN_MAX : grown[LEN_W-1:0];
        end else if (gap_count != GAP_COUNT_MAX) begin
          gap_count = gap_count + 1'b1;
          if (gap_count == gap_ticks) begin
            r.show = 1'b1;
            r.digit = decode_letter();
            letter = "";
            letter_overflow = 1'b0;
          end else begin
            r.reload = 1'b1;
          end
        end else begin
          r.reload = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    key_result_t want;
    if (rst) begin
      dot_min = DOT_MIN_RESET;
      dash_split = DASH_SPLIT_RESET;
      dash_max = DASH_MAX_RESET;
      gap_ticks = GAP_TICKS_RESET;
      held_len = '0;
      held_start = '0;
      in_gap = 1'b0;
      gap_count = '0;
      letter = "";
      letter_overflow = 1'b0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_DOT_MIN:    dot_min = cfg_data;
          REG_DASH_SPLIT: dash_split = cfg_data;
          REG_DASH_MAX:   dash_max = cfg_data;
          REG_GAP_TICKS:  gap_ticks = cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (show %0b digit %0d)",
                                    show, digit));
        end else begin
          want = result_q.pop_front();
          if (show !== want.show)
            report_mismatch($sformatf("show got %0b, expected %0b", show, want.show));
          if (digit !== want.digit)
            report_mismatch($sformatf("digit got %0d, expected %0d", digit, want.digit));
          if (reload_timer !== want.reload)
            report_mismatch($sformatf("reload_timer got %0b, expected %0b",
                                      reload_timer, want.reload));
          if (want.show) shown++;
        end
        checked++;
      end
      if (in_valid && in_ready) result_q.push_back(predict_key(cmd_t'(cmd), capture_time));
    end
    fail_count <= mismatches;
    pending <= result_q.size();
    letters_seen <= shown;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mhd_pkg::*;
  import morse_code_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {KEY_DOT, KEY_DASH, KEY_BAD} key_kind_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_DOT_MIN;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         cmd = CMD_NONE;
  logic [CAP_W-1:0]   capture_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               show;
  logic [DIGIT_W-1:0] digit;
  logic               reload_timer;

  int          fail_count, pending, letters_seen;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_results = 0;
  int          requests_sent = 0;
  int          settings_written = 0;
  int          quiet_cycles = 0;
  int unsigned dot_min_set = DOT_MIN_RESET;
  int unsigned dash_split_set = DASH_SPLIT_RESET;
  int unsigned dash_max_set = DASH_MAX_RESET;
  int unsigned gap_set = GAP_TICKS_RESET;

  morse_hex_digit_decoder DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .show(show), .digit(digit), .reload_timer(reload_timer)
  );

  morse_digit_checker u_digit_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .show(show), .digit(digit), .reload_timer(reload_timer),
    .fail_count(fail_count), .pending(pending), .letters_seen(letters_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random backpressure, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("FAIL morse_hex_digit_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input cmd_t c, input logic [CAP_W-1:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    capture_time <= t;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input int unsigned dm, input int unsigned ds,
                                input int unsigned dx, input int unsigned gt);
    dot_min_set = dm;
    dash_split_set = ds;
    dash_max_set = dx;
    gap_set = gt;
    cfg_we <= 1'b1;
    cfg_index <= REG_DOT_MIN;
    cfg_data <= CFG_W'(dm);
    @(posedge clk);
    cfg_index <= REG_DASH_SPLIT;
    cfg_data <= CFG_W'(ds);
    @(posedge clk);
    cfg_index <= REG_DASH_MAX;
    cfg_data <= CFG_W'(dx);
    @(posedge clk);
    cfg_index <= REG_GAP_TICKS;
    cfg_data <= CFG_W'(gt);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  function automatic int unsigned key_length(input key_kind_t kind);
    if (kind == KEY_DOT && dash_split_set > dot_min_set + 1)
      return $urandom_range(dash_split_set - 1, dot_min_set + 1);
    if (kind == KEY_DASH && dash_max_set > dash_split_set + 1)
      return $urandom_range(dash_max_set - 1, dash_split_set + 1);
    case ($urandom_range(4))
      0: return dot_min_set;
      1: return dash_split_set;
      2: return dash_max_set;
      3: return $urandom_range(dot_min_set);
      default: return $urandom_range(1200000, dash_max_set);
    endcase
  endfunction

  task automatic key_symbol(input key_kind_t kind);
    int unsigned span, start, stop;
    span = key_length(kind);
    start = $urandom_range(65535);
    stop = start + span;
    send_request(CMD_PRESS, CAP_W'(start));
    repeat (stop >> 16) send_request(CMD_TICK, CAP_W'($urandom));
    send_request(CMD_RELEASE, CAP_W'(stop));
  endtask

  task automatic send_letter();
    string       pattern;
    int          n;
    bit          noisy;
    int unsigned pause;
    key_kind_t   kind;
    noisy = ($urandom_range(9) == 0);
    if (noisy) begin
      n = $urandom_range(7, 1);
    end else begin
      pattern = hex_morse($urandom_range(15));
      n = pattern.len();
    end
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(3) == 0) begin
        send_request(CMD_RELEASE, CAP_W'($urandom));
      end else begin
        if (noisy) kind = key_kind_t'($urandom_range(2));
        else kind = (pattern[i] == ".") ? KEY_DOT : KEY_DASH;
        key_symbol(kind);
      end
      if (i != n - 1) begin
        pause = ($urandom_range(3) == 0) ? gap_set - 1
                                         : $urandom_range((gap_set > 3) ? 2 : gap_set - 1);
        repeat (pause) send_request(CMD_TICK, CAP_W'($urandom));
      end
      if ($urandom_range(19) == 0) send_request(CMD_NONE, CAP_W'($urandom));
    end
    repeat (gap_set + $urandom_range(3)) send_request(CMD_TICK, CAP_W'($urandom));
  endtask

  task automatic run_phase(input int tx, input int rx, input int unsigned dm,
                           input int unsigned ds, input int unsigned dx,
                           input int unsigned gt, input int count);
    int goal;
    drain_results();
    write_settings(dm, ds, dx, gt);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    hold_results = 1;
    goal = requests_sent + count;
    while (requests_sent < goal) send_letter();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 9;
    rx_idle_pct = 81;
    send_request(CMD_NONE, 16'hFFFF);
    send_request(CMD_RELEASE, 16'hFFFF);
    send_request(CMD_PRESS, 16'hFFFF);
    send_request(CMD_RELEASE, 16'h0000);
    send_request(CMD_PRESS, 16'h0000);
    send_request(CMD_RELEASE, 16'(DOT_MIN_RESET));
    send_request(CMD_PRESS, 16'h0000);
    send_request(CMD_RELEASE, 16'd40000);
    send_request(CMD_PRESS, 16'h0000);
    send_request(CMD_RELEASE, 16'd40000);
    send_request(CMD_PRESS, 16'h0000);
    send_request(CMD_RELEASE, 16'd40000);
    repeat (GAP_TICKS_RESET) send_request(CMD_TICK, 16'h0000);
    drain_results();
    // raise the gap length mid-gap so the cleared buffer decodes, then saturate
    write_settings(DOT_MIN_RESET, DASH_SPLIT_RESET, DASH_MAX_RESET, GAP_COUNT_MAX);
    repeat (int'(GAP_COUNT_MAX) - int'(GAP_TICKS_RESET) + 1)
      send_request(CMD_TICK, 16'hFFFF);

    run_phase(9, 81, DOT_MIN_RESET, DASH_SPLIT_RESET, DASH_MAX_RESET, GAP_TICKS_RESET, 200);
    run_phase(81, 9, 0, 5000, LEN_MAX, 1, 200);
    run_phase(0, 0, 100, 20000, 60000, GAP_COUNT_MAX, 300);
    run_phase(0, 0, LEN_MAX, 0, 0, 3, 50);
    drain_results();

    $display("Covered %0d requests under %0d threshold settings, %0d letters decoded",
             requests_sent, settings_written, letters_seen);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("PASS morse_hex_digit_decoder");
    end else begin
      $display("FAIL morse_hex_digit_decoder");
    end
    $finish;
  end

endmodule

// ===== morse_hex_digit_decoder.f =====
+incdir+src
src/mhd_pkg.sv
src/mhd_symbol.sv
src/mhd_match.sv
src/morse_hex_digit_decoder.sv
src/mhd_checker.sv
sim/morse_digit_checker.sv
sim/testbench.sv
